// ----- src/gap_aware_weighted_smoother_core_defines.svh -----
// Assertion helpers used by the bound checker gaws_chk.
`ifndef GAP_AWARE_WEIGHTED_SMOOTHER_CORE_DEFINES_SVH
`define GAP_AWARE_WEIGHTED_SMOOTHER_CORE_DEFINES_SVH

// Clocked assertion, muted while reset is asserted.
`define GAWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define GAWS_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/gaws_pkg.sv -----
`default_nettype none
package gaws_pkg;
    localparam int XMAX_W  = 16;
    localparam int SUM_W   = 32;
    localparam int CNT_W   = 16;
    localparam int COEF_W  = 16;
    localparam int CIDX_W  = 5;
    localparam int LW_W    = 6;
    localparam int GAP_W   = 12;
    localparam int MEAN_W  = 48;
    localparam int FRAC_W  = 16;
    localparam int RES_W   = 32;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_COL  = 1'b1;

    localparam logic CFG_LOOK_WIDTH = 1'b0;
    localparam logic CFG_GAP_LIMIT  = 1'b1;

    typedef struct packed {
        logic                     is_col;
        logic                     load_ok;
        logic [CIDX_W-1:0]        cidx;
        logic [COEF_W-1:0]        cval;
        logic [XMAX_W-1:0]        x;
        logic                     present;
        logic signed [SUM_W-1:0]  vsum;
        logic [CNT_W-1:0]         vcnt;
        logic                     last;
    } t_item;
endpackage
`default_nettype wire

// ----- src/gap_aware_weighted_smoother_core.sv -----
// Flow: a coefficient load is written into the table while the back end is idle. A column
//   that gives a result runs a serial mean divide, one window term per cycle over 2*L-1
//   terms (L = look width), a drain of the read and product pipeline and, unless the
//   coefficient sum is zero, a second serial divide.
// The back end takes one item at a time; a closing column walks once per flushed result.
// Reset: clears the queue, window valid flags, column count and line state; the
//   window memory and coefficient table are not cleared and no clearing pass runs.
`default_nettype none
module gap_aware_weighted_smoother_core
    import gaws_pkg::*;
#(
    parameter int MAX_TAPS   = 32,
    parameter int COORD_BITS = 12,
    localparam int IN_W  = ((70 + COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((COORD_BITS + 32 + 7) / 8) * 8
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // slave side
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // coef_index, coef_value, x_coord, present, sample total, sample count
    input  wire logic [IN_W-1:0]   i_s_tdata,
    // func
    input  wire logic [0:0]        i_s_tuser,
    // last
    input  wire logic              i_s_tlast,
    // master side
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // out_x, smoothed
    output logic [OUT_W-1:0]       o_m_tdata,
    // line_break
    output logic [0:0]             o_m_tuser,
    // final_res
    output logic                   o_m_tlast,
    // configuration writes
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [GAP_W-1:0]  i_cfg_data
);
    localparam int X_LO = CIDX_W + COEF_W;
    localparam int P_B  = X_LO + COORD_BITS;
    localparam int S_LO = P_B + 1;
    localparam int C_LO = S_LO + SUM_W;

    logic [LW_W-1:0]        r_look_width;
    logic [GAP_W-1:0]       r_gap_limit;
    t_item                  in_item;
    logic                   q_vld;
    logic                   q_rdy;
    t_item                  q_item;
    logic [COORD_BITS-1:0]  out_x;
    logic signed [RES_W-1:0] out_v;

    // Register writes land at once; user writes only while the block is idle, unchecked.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look_width <= LW_W'(30);
            r_gap_limit  <= GAP_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOOK_WIDTH: r_look_width <= i_cfg_data[LW_W-1:0];
                CFG_GAP_LIMIT:  r_gap_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the slave transaction into one item record.
    always_comb begin
        in_item.is_col  = (i_s_tuser[0] == FUNC_COL);
        in_item.load_ok = 1'b0;
        in_item.cidx    = i_s_tdata[CIDX_W-1:0];
        in_item.cval    = i_s_tdata[X_LO-1:CIDX_W];
        in_item.x       = XMAX_W'(i_s_tdata[P_B-1:X_LO]);
        in_item.present = i_s_tdata[P_B];
        in_item.vsum    = $signed(i_s_tdata[C_LO-1:S_LO]);
        in_item.vcnt    = i_s_tdata[C_LO+CNT_W-1:C_LO];
        in_item.last    = i_s_tlast;
    end

    // Front: accept and classify; queue decouples it from the arithmetic.
    gaws_front #(.MAX_TAPS(MAX_TAPS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_s_tvalid),
        .o_rdy    (o_s_tready),
        .i_item   (in_item),
        .o_q_vld  (q_vld),
        .i_q_rdy  (q_rdy),
        .o_q_item (q_item)
    );

    // Back: window, weighted walk, divides and the output register.
    gaws_back #(.MAX_TAPS(MAX_TAPS), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_vld      (q_vld),
        .o_q_rdy      (q_rdy),
        .i_q_item     (q_item),
        .i_look_width (r_look_width),
        .i_gap_limit  (r_gap_limit),
        .o_vld        (o_m_tvalid),
        .i_rdy        (i_m_tready),
        .o_x          (out_x),
        .o_smoothed   (out_v),
        .o_brk        (o_m_tuser[0]),
        .o_fin        (o_m_tlast)
    );

    assign o_m_tdata = OUT_W'({out_v, out_x});
endmodule
`default_nettype wire

// ----- src/gaws_ram.sv -----
`default_nettype none
module gaws_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- src/gaws_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, floor rounding for a
// signed dividend over a positive divisor.
module gaws_div
#(
    parameter int NUM_W = 56,
    parameter int DEN_W = 24
)
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W:0]   i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    output logic                         o_done,
    output logic signed [NUM_W:0]        o_quo
);
    localparam int CTW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_neg;
    logic [CTW-1:0]   r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_nx;
    logic [NUM_W:0]   mag;
    logic [NUM_W:0]   qext;

    always_comb begin
        rem_sh = {r_rem, r_q[NUM_W-1]};
        ge     = (rem_sh >= {1'b0, r_den});
        rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        mag    = i_num[NUM_W] ? (-i_num) : i_num;
        qext   = {1'b0, r_q} + {{NUM_W{1'b0}}, (r_neg && (r_rem != '0))};
        o_quo  = r_neg ? $signed(-qext) : $signed(qext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CTW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= mag[NUM_W-1:0];
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NUM_W];
            r_cnt <= CTW'(NUM_W);
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= rem_nx[DEN_W-1:0];
            r_cnt <= r_cnt - CTW'(1);
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

// ----- src/gaws_front.sv -----
`default_nettype none
// Accept and classify items, hold them in a two-entry queue.
module gaws_front
    import gaws_pkg::*;
#(
    parameter int MAX_TAPS = 32
)
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_vld,
    output logic       o_rdy,
    input  wire t_item i_item,
    output logic       o_q_vld,
    input  wire logic  i_q_rdy,
    output t_item      o_q_item
);
    t_item      r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      cls;
    logic       push;
    logic       pop;

    always_comb begin
        cls         = i_item;
        cls.load_ok = (int'(i_item.cidx) < MAX_TAPS);
        // a zero sample count counts as one
        if (i_item.vcnt == '0) begin
            cls.vcnt = CNT_W'(1);
        end
    end

    assign o_rdy    = (r_cnt != 2'd2);
    assign push     = i_vld && o_rdy;
    assign o_q_vld  = (r_cnt != 2'd0);
    assign pop      = o_q_vld && i_q_rdy;
    assign o_q_item = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= cls;
        end
    end
endmodule
`default_nettype wire

// ----- src/gaws_back.sv -----
`default_nettype none
// Window store, weighted sum walk, divisions and result staging.
module gaws_back
    import gaws_pkg::*;
#(
    parameter int MAX_TAPS   = 32,
    parameter int COORD_BITS = 12
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_vld,
    output logic                        o_q_rdy,
    input  wire t_item                  i_q_item,
    input  wire logic [LW_W-1:0]        i_look_width,
    input  wire logic [GAP_W-1:0]       i_gap_limit,
    output logic                        o_vld,
    input  wire logic                   i_rdy,
    output logic [COORD_BITS-1:0]       o_x,
    output logic signed [RES_W-1:0]     o_smoothed,
    output logic                        o_brk,
    output logic                        o_fin
);
    localparam int WIN   = 2 * MAX_TAPS;
    localparam int AW    = $clog2(WIN);
    localparam int CW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = 64 + AW;
    localparam int DIV_W = 48 + AW;
    localparam int CS_W  = 16 + AW;
    localparam int BW    = COORD_BITS + 13;
    localparam int RW    = COORD_BITS + MEAN_W;
    localparam int PR_W  = MEAN_W + COEF_W + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MDIV  = 9'b000000010,
        S_CHK   = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_TERM  = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_QWAIT = 9'b001000000,
        S_PUT   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    localparam logic signed [DIV_W:0] SMAX = $signed({{(DIV_W-31){1'b0}}, 32'h7fffffff});
    localparam logic signed [DIV_W:0] SMIN = $signed({{(DIV_W-31){1'b1}}, 32'h80000000});

    function automatic logic [AW-1:0] f_addr(input logic [AW-1:0] wp, input logic [AW-1:0] age);
        logic [AW:0] d;
        d = {1'b0, wp} - {1'b0, age};
        if (d[AW]) begin
            d = d + (AW+1)'(WIN);
        end
        return d[AW-1:0];
    endfunction

    t_state                  r_state;
    t_state                  n_state;
    t_item                   r_item;
    logic [TW-1:0]           r_L;
    logic [TW-1:0]           n_L;
    logic [AW-1:0]           r_wp;
    logic [WIN-1:0]          r_valid;
    logic [TW-1:0]           r_cnt;
    logic [AW-1:0]           r_age;
    logic [CW-1:0]           r_j;
    logic                    r_side;
    logic                    r_flush;
    logic [TW-1:0]           r_k;
    logic                    r_s1_vld;
    logic                    r_s1_inc;
    logic                    r_s1_ctr;
    logic                    r_p_vld;
    logic signed [PR_W-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [CS_W-1:0]         r_csum;
    logic [COORD_BITS-1:0]   r_ex;
    logic [COORD_BITS-1:0]   r_res_x;
    logic [RES_W-1:0]        r_res_v;
    logic                    r_res_brk;
    logic [COORD_BITS-1:0]   r_prev_x;
    logic                    r_have_prev;
    logic                    r_hold_vld;
    logic [COORD_BITS-1:0]   r_hold_x;
    logic [RES_W-1:0]        r_hold_v;
    logic                    r_hold_brk;
    logic                    r_out_vld;
    logic [COORD_BITS-1:0]   r_out_x;
    logic [RES_W-1:0]        r_out_v;
    logic                    r_out_brk;
    logic                    r_out_fin;

    logic [AW-1:0]           wp_next;
    logic [AW-1:0]           t_age;
    logic [AW-1:0]           t_addr;
    logic                    t_inc;
    logic                    last_term;
    logic [AW-1:0]           ctr_age;
    logic [AW-1:0]           scan_age;
    logic                    emit_start;
    logic [AW-1:0]           emit_age;
    logic                    out_free;
    logic                    out_push;
    logic [COORD_BITS-1:0]   push_x;
    logic [RES_W-1:0]        push_v;
    logic                    push_brk;
    logic                    push_fin;
    logic                    fin_res;
    logic [RES_W-1:0]        fin_v;
    logic signed [BW-1:0]    sdiff;
    logic                    brk;

    logic                    div_start;
    logic signed [DIV_W:0]   div_num;
    logic [CS_W-1:0]         div_den;
    logic                    div_done;
    logic signed [DIV_W:0]   div_quo;

    logic                    win_we;
    logic [RW-1:0]           win_rd;
    logic                    coef_we;
    logic [COEF_W-1:0]       coef_rd;
    logic signed [MEAN_W-1:0] rd_mean;

    gaws_ram #(.WIDTH(RW), .DEPTH(WIN)) u_win (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (wp_next),
        .i_wdata ({r_item.x[COORD_BITS-1:0], div_quo[MEAN_W-1:0]}),
        .i_raddr (t_addr),
        .o_rdata (win_rd)
    );

    gaws_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (CW'(i_q_item.cidx)),
        .i_wdata (i_q_item.cval),
        .i_raddr (r_j),
        .o_rdata (coef_rd)
    );

    gaws_div #(.NUM_W(DIV_W), .DEN_W(CS_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign rd_mean = $signed(win_rd[MEAN_W-1:0]);

    always_comb begin
        if (i_look_width == '0) begin
            n_L = TW'(1);
        end else if (int'(i_look_width) > MAX_TAPS) begin
            n_L = TW'(MAX_TAPS);
        end else begin
            n_L = TW'(i_look_width);
        end

        wp_next   = (r_wp == AW'(WIN - 1)) ? '0 : (r_wp + AW'(1));
        t_age     = r_side ? (r_age - AW'(r_j)) : (r_age + AW'(r_j));
        t_addr    = f_addr(r_wp, t_age);
        t_inc     = r_side ? ((r_age >= AW'(r_j)) && r_valid[t_addr]) : r_valid[t_addr];
        last_term = (r_j == CW'(r_L - TW'(1))) && (r_side || (r_j == '0));
        ctr_age   = AW'(r_L - TW'(1));
        scan_age  = AW'(r_k - TW'(1));

        out_free  = !r_out_vld || i_rdy;

        sdiff = $signed(BW'(r_ex)) - $signed(BW'(r_prev_x));
        brk   = r_have_prev && (sdiff > $signed(BW'(i_gap_limit)));

        if (div_quo > SMAX) begin
            fin_v = 32'h7fffffff;
        end else if (div_quo < SMIN) begin
            fin_v = 32'h80000000;
        end else begin
            fin_v = div_quo[RES_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        o_q_rdy    = 1'b0;
        div_start  = 1'b0;
        div_num    = $signed({{(DIV_W-47){i_q_item.vsum[SUM_W-1]}}, i_q_item.vsum, 16'h0});
        div_den    = CS_W'(i_q_item.vcnt);
        coef_we    = 1'b0;
        win_we     = 1'b0;
        emit_start = 1'b0;
        emit_age   = ctr_age;
        fin_res    = 1'b0;
        out_push   = 1'b0;
        push_x     = r_res_x;
        push_v     = r_res_v;
        push_brk   = r_res_brk;
        push_fin   = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_q_rdy = 1'b1;
                if (i_q_vld) begin
                    if (i_q_item.is_col) begin
                        div_start = 1'b1;
                        n_state   = S_MDIV;
                    end else begin
                        coef_we = i_q_item.load_ok;
                    end
                end
            end
            S_MDIV: begin
                if (div_done) begin
                    win_we  = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_item.last) begin
                    n_state = S_SCAN;
                end else if ((r_cnt >= r_L) && r_valid[f_addr(r_wp, ctr_age)]) begin
                    emit_start = 1'b1;
                    n_state    = S_TERM;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                emit_age = scan_age;
                if (r_k == '0) begin
                    n_state = S_FIN;
                end else if (r_valid[f_addr(r_wp, scan_age)]) begin
                    emit_start = 1'b1;
                    n_state    = S_TERM;
                end
            end
            S_TERM: begin
                if (last_term) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                div_num = $signed({r_acc[ACC_W-1], r_acc[ACC_W-1:FRAC_W]});
                div_den = r_csum;
                if (!r_s1_vld && !r_p_vld) begin
                    if (r_csum == '0) begin
                        fin_res = 1'b1;
                        n_state = S_PUT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_QWAIT;
                    end
                end
            end
            S_QWAIT: begin
                if (div_done) begin
                    fin_res = 1'b1;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_flush) begin
                    if (out_free) begin
                        out_push = 1'b1;
                        n_state  = S_IDLE;
                    end
                end else if (!r_hold_vld) begin
                    n_state = S_SCAN;
                end else if (out_free) begin
                    out_push = 1'b1;
                    push_x   = r_hold_x;
                    push_v   = r_hold_v;
                    push_brk = r_hold_brk;
                    n_state  = S_SCAN;
                end
            end
            S_FIN: begin
                push_x   = r_hold_x;
                push_v   = r_hold_v;
                push_brk = r_hold_brk;
                push_fin = 1'b1;
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    out_push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_valid     <= '0;
            r_cnt       <= '0;
            r_s1_vld    <= 1'b0;
            r_p_vld     <= 1'b0;
            r_have_prev <= 1'b0;
            r_hold_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_flush     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= (r_state == S_TERM);
            r_p_vld  <= r_s1_vld && r_s1_inc;

            if (win_we) begin
                r_wp             <= wp_next;
                r_valid[wp_next] <= r_item.present;
                if (r_cnt != TW'(MAX_TAPS)) begin
                    r_cnt <= r_cnt + TW'(1);
                end
            end

            if ((r_state == S_CHK)) begin
                r_flush <= r_item.last;
            end

            if (fin_res) begin
                r_have_prev <= 1'b1;
            end

            if ((r_state == S_PUT) && r_flush && (n_state == S_SCAN)) begin
                r_hold_vld <= 1'b1;
            end

            // end of series: drop the window and the line state
            if ((r_state == S_FIN) && (n_state == S_IDLE)) begin
                r_hold_vld  <= 1'b0;
                r_valid     <= '0;
                r_cnt       <= '0;
                r_have_prev <= 1'b0;
            end

            if (out_push) begin
                r_out_vld <= 1'b1;
            end else if (i_rdy) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_q_vld) begin
            r_item <= i_q_item;
            r_L    <= n_L;
        end

        if ((r_state == S_CHK) && r_item.last) begin
            r_k <= (r_cnt < r_L) ? r_cnt : r_L;
        end else if ((r_state == S_SCAN) && (r_k != '0)) begin
            r_k <= r_k - TW'(1);
        end

        if (emit_start) begin
            r_age  <= emit_age;
            r_j    <= '0;
            r_side <= 1'b0;
        end else if (r_state == S_TERM) begin
            if (r_j == '0) begin
                r_j <= CW'(1);
            end else if (!r_side) begin
                r_side <= 1'b1;
            end else begin
                r_j    <= r_j + CW'(1);
                r_side <= 1'b0;
            end
        end

        r_s1_inc <= t_inc;
        r_s1_ctr <= (r_j == '0);
        r_prod   <= rd_mean * $signed({1'b0, coef_rd});

        if (emit_start) begin
            r_acc  <= '0;
            r_csum <= '0;
        end else begin
            if (r_p_vld) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (r_s1_vld && r_s1_inc) begin
                r_csum <= r_csum + CS_W'(coef_rd);
            end
        end

        if (r_s1_vld && r_s1_ctr) begin
            r_ex <= win_rd[RW-1:MEAN_W];
        end

        if (fin_res) begin
            r_res_x   <= r_ex;
            r_res_v   <= (r_state == S_DRAIN) ? '0 : fin_v;
            r_res_brk <= brk;
            r_prev_x  <= r_ex;
        end

        if ((r_state == S_PUT) && r_flush && (n_state == S_SCAN)) begin
            r_hold_x   <= r_res_x;
            r_hold_v   <= r_res_v;
            r_hold_brk <= r_res_brk;
        end

        if (out_push) begin
            r_out_x   <= push_x;
            r_out_v   <= push_v;
            r_out_brk <= push_brk;
            r_out_fin <= push_fin;
        end
    end

    assign o_vld      = r_out_vld;
    assign o_x        = r_out_x;
    assign o_smoothed = $signed(r_out_v);
    assign o_brk      = r_out_brk;
    assign o_fin      = r_out_fin;
endmodule
`default_nettype wire

// ----- src/gaws_chk.sv -----
`default_nettype none
`include "gap_aware_weighted_smoother_core_defines.svh"
module gaws_chk
#(
    parameter int COORD_BITS = 12,
    localparam int OUT_W = ((COORD_BITS + 32 + 7) / 8) * 8
)
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_s_tvalid,
    input wire logic             o_s_tready,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata,
    input wire logic [0:0]       o_m_tuser,
    input wire logic             o_m_tlast
);
    // reset empties the output stage and opens the input
    `GAWS_ASSERT_RST(a_rst_clear, i_clk, !i_rst_n |=> (!o_m_tvalid && o_s_tready), "reset did not clear")
    // a stalled result holds
    `GAWS_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)), "stalled result changed")
    // the input closes only after it has taken a transaction
    `GAWS_ASSERT(a_rdy_drop, i_clk, i_rst_n, $fell(o_s_tready) |-> $past(i_s_tvalid), "input ready fell with no transaction")
endmodule

bind gap_aware_weighted_smoother_core gaws_chk #(.COORD_BITS(COORD_BITS)) u_gaws_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

// ----- tb/gaws_checker.sv -----
`default_nettype none
// Watches the stream and configuration channels, predicts the smoothed
// results of the block and compares them against what comes out.
module gaws_checker
    import gaws_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [87:0] i_s_tdata,
    input  wire logic [0:0]  i_s_tuser,
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [47:0] i_m_tdata,
    input  wire logic [0:0]  i_m_tuser,
    input  wire logic        i_m_tlast,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS  = 32;
    localparam int DEPTH = 2 * TAPS;

    typedef struct {
        logic [11:0]        x;
        logic signed [31:0] smoothed;
        logic               brk;
        logic               fin;
    } t_smooth_res;

    t_smooth_res expected_q[$];

    longint      col_mean [DEPTH];
    bit          col_valid[DEPTH];
    int          col_xpos [DEPTH];
    longint      coef     [TAPS];
    int          col_count;
    int          last_out_x;
    bit          seen_out;
    int          look_reg;
    int          gap_reg;

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    // Weighted mean around one window entry; skip empty neighbors.
    function automatic void predict_one(int age, int taps_n, bit fin);
        logic signed [127:0] acc;
        logic signed [127:0] term;
        logic signed [127:0] quot;
        logic signed [127:0] den;
        longint              csum;
        t_smooth_res         r;
        acc  = 0;
        term = col_mean[age];
        acc  = term * coef[0];
        csum = coef[0];
        for (int j = 1; j < taps_n; j++) begin
            if (age + j < DEPTH && col_valid[age + j]) begin
                term = col_mean[age + j];
                acc  = acc + term * coef[j];
                csum += coef[j];
            end
            if (age >= j && col_valid[age - j]) begin
                term = col_mean[age - j];
                acc  = acc + term * coef[j];
                csum += coef[j];
            end
        end
        acc = acc >>> 16;
        if (csum == 0) begin
            quot = 0;
        end else begin
            den  = csum;
            quot = acc / den;
            if ((acc % den) != 0 && acc < 0) quot = quot - 1;
        end
        if (quot > 128'sd2147483647) quot = 128'sd2147483647;
        if (quot < -128'sd2147483648) quot = -128'sd2147483648;
        r.x        = col_xpos[age][11:0];
        r.smoothed = quot[31:0];
        r.brk      = seen_out && (col_xpos[age] - last_out_x > gap_reg);
        r.fin      = fin;
        last_out_x = col_xpos[age];
        seen_out   = 1'b1;
        expected_q.push_back(r);
    endfunction

    function automatic void take_item(logic [87:0] d, logic f, logic lst);
        int     taps_n;
        int     top;
        int     first_idx;
        longint s;
        longint c;
        taps_n = (look_reg == 0) ? 1 : (look_reg > TAPS ? TAPS : look_reg);
        if (f == FUNC_LOAD) begin
            coef[d[4:0]] = d[20:5];
            return;
        end
        s = longint'($signed(d[65:34]));
        c = d[81:66];
        if (c == 0) c = 1;
        for (int k = DEPTH - 1; k > 0; k--) begin
            col_mean[k]  = col_mean[k-1];
            col_valid[k] = col_valid[k-1];
            col_xpos[k]  = col_xpos[k-1];
        end
        col_mean[0]  = floor_quot(s * 65536, c);
        col_valid[0] = d[33];
        col_xpos[0]  = d[32:21];
        if (col_count < 8191) col_count++;
        if (!lst) begin
            if (col_count >= taps_n && col_valid[taps_n-1])
                predict_one(taps_n - 1, taps_n, 1'b0);
            return;
        end
        // Flush: emit every pending column, oldest first; mark the last one.
        top       = (col_count < taps_n) ? col_count : taps_n;
        first_idx = expected_q.size();
        for (int k = top; k > 0; k--)
            if (col_valid[k-1]) predict_one(k - 1, taps_n, 1'b0);
        if (expected_q.size() > first_idx)
            expected_q[expected_q.size()-1].fin = 1'b1;
        foreach (col_valid[k]) col_valid[k] = 1'b0;
        col_count = 0;
        seen_out  = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_smooth_res e;
        logic [11:0] ax;
        logic signed [31:0] asm;
        if (!i_rst_n) begin
            expected_q.delete();
            foreach (col_valid[k]) col_valid[k] = 1'b0;
            col_count  = 0;
            last_out_x = 0;
            seen_out   = 1'b0;
            look_reg   = 30;
            gap_reg    = 1;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_LOOK_WIDTH) look_reg = i_cfg_data[5:0];
                else gap_reg = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) take_item(i_s_tdata, i_s_tuser[0], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                ax  = i_m_tdata[11:0];
                asm = i_m_tdata[43:12];
                o_result_count++;
                if (expected_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("mismatch: unexpected result x=%0d smoothed=%0d", ax, asm);
                end else begin
                    e = expected_q.pop_front();
                    if (ax !== e.x || asm !== e.smoothed || i_m_tuser[0] !== e.brk
                            || i_m_tlast !== e.fin) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"mismatch: exp x=%0d sm=%0d brk=%0b fin=%0b,",
                                      " got x=%0d sm=%0d brk=%0b fin=%0b"},
                                     e.x, e.smoothed, e.brk, e.fin,
                                     ax, asm, i_m_tuser[0], i_m_tlast);
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end

    initial begin
        o_fail_count   = 0;
        o_result_count = 0;
        o_pending      = 0;
    end
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gaws_pkg::*;

    // Keep slack over the longest column walk with a full window.
    localparam int SETTLE     = 400;
    localparam int IDLE_LIMIT = 60000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [87:0] i_s_tdata;   // coef_index, coef_value, x_coord, present, sample total, count
    logic [0:0]  i_s_tuser;   // func
    logic        i_s_tlast;   // last
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;   // out_x, smoothed
    logic [0:0]  o_m_tuser;   // line_break
    logic        o_m_tlast;   // final_res
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int item_count;
    int cfg_count;
    int idle_cycles;
    int stall_hold;
    bit sink_calm;    // stretch with the sink always ready
    bit src_calm;     // stretch with no source gaps

    gap_aware_weighted_smoother_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    gaws_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser), .i_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sink side: random stalls, mostly short with an occasional long one.
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_calm) begin
            i_m_tready <= 1'b1;
            stall_hold <= 0;
        end else if (stall_hold > 0) begin
            i_m_tready <= 1'b0;
            stall_hold <= stall_hold - 1;
        end else if ($urandom_range(99) < 4) begin
            i_m_tready <= 1'b0;
            stall_hold <= $urandom_range(80, 20);
        end else begin
            i_m_tready <= ($urandom_range(99) >= 30);
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", pending);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (src_calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(4, 1);
        return $urandom_range(60, 10);
    endfunction

    // Send one transaction; lower valid first only when a gap comes before it.
    task automatic send_item(bit f, int cidx, int cval, int x, bit pres,
                             int sum, int cnt, bit lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata  <= {6'b0, cnt[15:0], sum[31:0], pres, x[11:0], cval[15:0], cidx[4:0]};
        i_s_tuser  <= f;
        i_s_tlast  <= lst;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        item_count++;
    endtask

    task automatic load_coef(int idx, int val);
        send_item(FUNC_LOAD, idx, val, $urandom_range(4095), $urandom_range(1),
                  $urandom, $urandom_range(65535), $urandom_range(1));
    endtask

    // Hold the source until every result is out and the block has settled.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, int val);
        i_cfg_index <= idx;
        i_cfg_data  <= val[11:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        cfg_count++;
    endtask

    function automatic int rand_sum();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(2000) - 1000;
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom_range(200000) - 100000;
        endcase
    endfunction

    function automatic int rand_count();
        case ($urandom_range(3))
            0: return 1;
            1: return $urandom_range(65535, 1);
            default: return $urandom_range(16, 1);
        endcase
    endfunction

    // One chart series of consecutive columns; the last one flushes.
    task automatic send_series(int len);
        int x;
        x = $urandom_range(4095);
        for (int i = 0; i < len; i++) begin
            // Now and then jump or step back to exercise the line-break logic.
            if ($urandom_range(99) < 6) x = x + $urandom_range(40, 2);
            else if ($urandom_range(99) < 3) x = x - $urandom_range(5, 1);
            send_item(FUNC_COL, $urandom_range(31), $urandom_range(32768), x,
                      $urandom_range(7) != 0, rand_sum(), rand_count(), i == len - 1);
            x++;
        end
    endtask

    initial begin
        int look;
        int series_len;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        item_count  = 0;
        cfg_count   = 0;
        idle_cycles = 0;
        stall_hold  = 0;
        sink_calm   = 1'b0;
        src_calm    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole coefficient table before any column is sent.
        for (int i = 0; i < 32; i++)
            load_coef(i, (i == 0) ? 32768 : (i == 31 ? 0 : $urandom_range(32768)));

        // Directed: reset widths, extreme sums, zero and full counts, gaps.
        send_item(FUNC_COL, 0, 0, 4095, 1, 32'h7fff_ffff, 1, 1'b0);
        send_item(FUNC_COL, 0, 0, 0, 1, 32'h8000_0000, 1, 1'b0);
        send_item(FUNC_COL, 0, 0, 1, 0, 12345, 3, 1'b0);
        send_item(FUNC_COL, 0, 0, 5, 1, -7, 0, 1'b0);
        send_item(FUNC_COL, 0, 0, 2, 1, 100, 65535, 1'b1);
        // Flush with nothing present gives no result.
        send_item(FUNC_COL, 0, 0, 10, 0, 5, 1, 1'b0);
        send_item(FUNC_COL, 0, 0, 11, 0, 5, 1, 1'b1);
        drain();

        // Single tap, zero gap limit; a zero center coefficient forces a zero sum.
        write_reg(CFG_LOOK_WIDTH, 1);
        write_reg(CFG_GAP_LIMIT, 0);
        load_coef(0, 0);
        send_item(FUNC_COL, 0, 0, 100, 1, -5000, 7, 1'b0);
        send_item(FUNC_COL, 0, 0, 103, 1, 77, 2, 1'b1);
        load_coef(0, 32768);
        send_item(FUNC_COL, 0, 0, 200, 1, -3, 2, 1'b0);
        send_item(FUNC_COL, 0, 0, 201, 1, 32'h8000_0000, 1, 1'b0);
        send_item(FUNC_COL, 0, 0, 203, 1, 9, 4, 1'b1);
        drain();

        // Width zero acts as one; width above the table clamps.
        write_reg(CFG_LOOK_WIDTH, 0);
        write_reg(CFG_GAP_LIMIT, 4095);
        send_series(3);
        drain();
        write_reg(CFG_LOOK_WIDTH, 63);
        send_series(4);
        drain();

        // Random phases: new settings, then a few series each.
        while (item_count < 310) begin
            case ($urandom_range(5))
                0: look = 32;
                1: look = $urandom_range(63);
                default: look = $urandom_range(6, 1);
            endcase
            write_reg(CFG_LOOK_WIDTH, look);
            write_reg(CFG_GAP_LIMIT,
                      $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(3));
            sink_calm = ($urandom_range(3) == 0);
            src_calm  = ($urandom_range(3) == 0);
            for (int s = 0; s < 3; s++) begin
                if ($urandom_range(3) == 0)
                    load_coef($urandom_range(31), $urandom_range(32768));
                series_len = ($urandom_range(4) == 0) ? $urandom_range(40, 10)
                                                      : $urandom_range(8, 1);
                send_series(series_len);
            end
            drain();
        end
        sink_calm = 1'b0;

        $display("sent %0d items and %0d register writes; checked %0d results",
                 item_count, cfg_count, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+src
src/gaws_pkg.sv
src/gaws_ram.sv
src/gaws_div.sv
src/gaws_front.sv
src/gaws_back.sv
src/gap_aware_weighted_smoother_core.sv
src/gaws_chk.sv
tb/gaws_checker.sv
tb/testbench.sv
